// File: src/ffha_pkg.sv
// Package for the first-fit heap allocator: sizes, field structs and state codes.
// Depends on nothing; every other file imports it.
package ffha_pkg;

    localparam int ArenaBytes  = 1024;
    localparam int HeaderBytes = 24;
    localparam int MaxBlocks   = ArenaBytes / HeaderBytes;
    localparam int IdxW        = $clog2(MaxBlocks + 1);
    localparam int OffW        = 11;
    localparam int SizeW       = 11;

    localparam logic [1:0] ST_GRANTED  = 2'd0;
    localparam logic [1:0] ST_NOMEM    = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;
    localparam logic [1:0] ST_IGNORED  = 2'd3;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] request_bytes;
        logic [10:0] release_offset;
    } in_item_t;

    typedef struct packed {
        logic [9:0] payload_offset;
        logic [1:0] status;
    } out_item_t;

    // One block header as held in the header memory.
    typedef struct packed {
        logic [OffW-1:0]  offset;
        logic [SizeW-1:0] size;
        logic             is_free;
    } hdr_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT_RD,
        S_SPLIT_WR,
        S_MRG_START,
        S_MRG_LOAD,
        S_MRG_RD,
        S_MRG_CHK,
        S_MRG_SH_RD,
        S_MRG_SH_WR,
        S_DONE
    } state_t;

endpackage

// File: src/ffha_hdr_ram.sv
// Header memory: one write port, one read port, registered read data.
// Depends on ffha_pkg.
module ffha_hdr_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ffha_pkg::IdxW-1:0]  waddr,
    input  ffha_pkg::hdr_t             wdata,
    input  logic [ffha_pkg::IdxW-1:0]  raddr,
    output ffha_pkg::hdr_t             rdata
);
    import ffha_pkg::*;

    hdr_t mem [MaxBlocks];

    // Synchronous write and read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: sequencer around the header memory.
// Depends on ffha_pkg and ffha_hdr_ram.
//
// Channel  | Direction | Payload     | Handshake
// in       | input     | in_item_t   | in_valid / in_stall
// out      | output    | out_item_t  | out_valid / out_stall
//
// The chain walk reads each header, then checks it. A split moves each later header
// up (read, then write), then writes the remainder; a release reloads entry zero,
// then checks each pair of neighbours and, on each merge, moves the later entries down.
// A DONE state loads the result; the header table holds at most 42 headers.
// Reset leaves one free block at entry zero and a count of one (entry zero is forced
// until first written, so no clearing pass is needed). A waiting result blocks input.
module first_fit_heap_allocator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ffha_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ffha_pkg::out_item_t out_data
);
    import ffha_pkg::*;

    state_t state_reg, state_next;
    logic [IdxW-1:0] cnt_reg, cnt_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic [IdxW-1:0] j_reg, j_next;
    logic [16:0] need_reg, need_next;
    logic        cmd_reg, cmd_next;
    logic [OffW-1:0] rel_reg, rel_next;
    hdr_t        cur_reg, cur_next;
    logic        init_reg, init_next;
    logic        ov_reg, ov_next;
    out_item_t   od_reg, od_next;
    logic [IdxW-1:0] raddr_reg;

    logic            we;
    logic [IdxW-1:0] waddr, raddr;
    hdr_t            wdata, rdata, rd;

    logic [17:0] split_lim;
    logic        fit_hit, fit_exact, fit_split, rel_hit, mrg_hit;

    ffha_hdr_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Address of the read whose data is on rdata now.
    always_ff @(posedge clk)
    begin
        raddr_reg <= raddr;
    end

    // Entry zero reads as the whole free arena until first written.
    always_comb
    begin
        rd = rdata;
        if (init_reg && (raddr_reg == '0))
        begin
            rd.offset  = '0;
            rd.size    = SizeW'(ArenaBytes - HeaderBytes);
            rd.is_free = 1'b1;
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // Decisions on the header just read.
    assign split_lim = {1'b0, need_reg} + 18'(HeaderBytes);
    assign fit_hit   = rd.is_free && (17'(rd.size) >= need_reg);
    assign fit_exact = (17'(rd.size) == need_reg);
    assign fit_split = (18'(rd.size) > split_lim) && (cnt_reg < IdxW'(MaxBlocks));
    assign rel_hit   = (12'(rd.offset) + 12'(HeaderBytes)) == 12'(rel_reg);
    assign mrg_hit   = cur_reg.is_free && rd.is_free;

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= IdxW'(1);
            init_reg  <= 1'b1;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            init_reg  <= init_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        j_reg    <= j_next;
        need_reg <= need_next;
        cmd_reg  <= cmd_next;
        rel_reg  <= rel_next;
        cur_reg  <= cur_next;
        od_reg   <= od_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = (idx_reg >= cnt_reg) ? S_DONE : S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (fit_hit)
                    begin
                        if (!fit_exact && fit_split)
                        begin
                            state_next = S_SPLIT_RD;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    state_next = rel_hit ? S_MRG_START : S_SCAN_RD;
                end
            end
            S_SPLIT_RD:
            begin
                state_next = S_SPLIT_WR;
            end
            S_SPLIT_WR:
            begin
                state_next = (j_reg == idx_reg + IdxW'(1)) ? S_DONE : S_SPLIT_RD;
            end
            S_MRG_START:
            begin
                state_next = S_MRG_LOAD;
            end
            S_MRG_LOAD:
            begin
                state_next = S_MRG_RD;
            end
            S_MRG_RD:
            begin
                state_next = (idx_reg + IdxW'(1) >= cnt_reg) ? S_DONE : S_MRG_CHK;
            end
            S_MRG_CHK:
            begin
                state_next = mrg_hit ? S_MRG_SH_RD : S_MRG_RD;
            end
            S_MRG_SH_RD:
            begin
                state_next = (j_reg >= cnt_reg) ? S_MRG_RD : S_MRG_SH_WR;
            end
            S_MRG_SH_WR:
            begin
                state_next = S_MRG_SH_RD;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control. Each state issues at most one read and one write.
    always_comb
    begin
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        j_next    = j_reg;
        need_next = need_reg;
        cmd_next  = cmd_reg;
        rel_next  = rel_reg;
        cur_next  = cur_reg;
        init_next = init_reg;
        ov_next   = ov_reg && out_stall;
        od_next   = od_reg;
        we        = 1'b0;
        waddr     = idx_reg;
        wdata     = cur_reg;
        raddr     = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd_next  = in_data.command;
                    need_next = ({1'b0, in_data.request_bytes} + 17'd3) & ~17'd3;
                    rel_next  = in_data.release_offset;
                    idx_next  = '0;
                    od_next   = '{payload_offset: '0, status: ST_NOMEM};
                    if (in_data.command == CMD_RELEASE)
                    begin
                        od_next.status = ST_IGNORED;
                    end
                end
            end
            S_SCAN_RD:
            begin
                raddr = idx_reg;
            end
            S_SCAN_CHK:
            begin
                idx_next = idx_reg + IdxW'(1);
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (fit_hit)
                    begin
                        idx_next = idx_reg;
                        if (fit_exact)
                        begin
                            we             = 1'b1;
                            wdata          = rd;
                            wdata.is_free  = 1'b0;
                            od_next.status = ST_GRANTED;
                            od_next.payload_offset = 10'(rd.offset + OffW'(HeaderBytes));
                        end
                        else if (fit_split)
                        begin
                            // Granted part is written now; later headers move up next.
                            we             = 1'b1;
                            wdata.offset   = rd.offset;
                            wdata.size     = SizeW'(need_reg);
                            wdata.is_free  = 1'b0;
                            cur_next       = rd;
                            j_next         = cnt_reg;
                            od_next.status = ST_GRANTED;
                            od_next.payload_offset = 10'(rd.offset + OffW'(HeaderBytes));
                        end
                    end
                end
                else if (rel_hit)
                begin
                    we             = 1'b1;
                    wdata          = rd;
                    wdata.is_free  = 1'b1;
                    od_next.status = ST_RELEASED;
                    idx_next       = '0;
                end
            end
            S_SPLIT_RD:
            begin
                raddr = j_reg - IdxW'(1);
            end
            S_SPLIT_WR:
            begin
                we    = 1'b1;
                waddr = j_reg;
                if (j_reg == idx_reg + IdxW'(1))
                begin
                    // Remainder block behind the granted part.
                    wdata.offset  = cur_reg.offset + OffW'(HeaderBytes) + OffW'(need_reg);
                    wdata.size    = cur_reg.size - SizeW'(need_reg) - SizeW'(HeaderBytes);
                    wdata.is_free = 1'b1;
                    cnt_next      = cnt_reg + IdxW'(1);
                end
                else
                begin
                    wdata  = rd;
                    j_next = j_reg - IdxW'(1);
                end
            end
            S_MRG_START:
            begin
                raddr = '0;
            end
            S_MRG_LOAD:
            begin
                cur_next = rd;
            end
            S_MRG_RD:
            begin
                raddr = idx_reg + IdxW'(1);
            end
            S_MRG_CHK:
            begin
                if (mrg_hit)
                begin
                    cur_next.size = cur_reg.size + rd.size + SizeW'(HeaderBytes);
                    we            = 1'b1;
                    waddr         = idx_reg;
                    wdata.size    = cur_reg.size + rd.size + SizeW'(HeaderBytes);
                    j_next        = idx_reg + IdxW'(2);
                end
                else
                begin
                    cur_next = rd;
                    idx_next = idx_reg + IdxW'(1);
                end
            end
            S_MRG_SH_RD:
            begin
                raddr = j_reg;
                if (j_reg >= cnt_reg)
                begin
                    cnt_next = cnt_reg - IdxW'(1);
                end
            end
            S_MRG_SH_WR:
            begin
                we     = 1'b1;
                waddr  = j_reg - IdxW'(1);
                wdata  = rd;
                j_next = j_reg + IdxW'(1);
            end
            S_DONE:
            begin
                ov_next = 1'b1;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
        // The forced view of entry zero ends with its first write.
        if (we && (waddr == '0))
        begin
            init_next = 1'b0;
        end
    end
endmodule

// File: src/ffha_checker.sv
// Port-level checker for the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg.
module ffha_port_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input ffha_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input ffha_pkg::out_item_t out_data
);
    import ffha_pkg::*;

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    // No new transaction while a result waits.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    // Only grants carry an offset.
    a_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_GRANTED |-> out_data.payload_offset == '0)
        else $error("offset on non-grant");

    // An accepted transaction closes the input side next cycle.
    a_acc: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not closed after acceptance");
endmodule

bind first_fit_heap_allocator ffha_port_checker u_ffha_checker (.*);
